// File: rtl/wcm_pkg.sv
// Shared types, constants and helpers of the word concatenation matcher.
`timescale 1ns / 1ps
`default_nettype none
package wcm_pkg;

   localparam int MAX_WORD_LEN = 8;
   localparam int MAX_WORDS    = 16;
   localparam int PH_W         = $clog2(MAX_WORD_LEN);
   localparam int ENT_W        = $clog2(MAX_WORDS);
   localparam int NUM_W        = ENT_W + 1;
   localparam int SLOT_W       = PH_W + ENT_W;
   localparam int SLOTS        = MAX_WORD_LEN * MAX_WORDS;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_ADD     = 2'd1,
      ACT_TEXT    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   localparam logic [1:0] KIND_MATCH     = 2'd0;
   localparam logic [1:0] KIND_DICT_FULL = 2'd1;
   localparam logic [1:0] KIND_POS_SAT   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD,
      S_SEARCH,
      S_POP_RING,
      S_POP_CNT,
      S_POP_WR,
      S_PUSH_RD,
      S_PUSH_WR,
      S_CHECK,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      CTX_PRE,
      CTX_LOOP,
      CTX_FINAL
   } ctx_type;

   function automatic logic [3:0] eff_len(input logic [3:0] raw);
      logic [3:0] l;
      l = raw;
      if (l == 4'd0) l = 4'd1;
      if (l > 4'(MAX_WORD_LEN)) l = 4'(MAX_WORD_LEN);
      return l;
   endfunction

   function automatic logic [63:0] len_mask(input logic [3:0] l);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < l) m[8*b +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// File: rtl/word_concatenation_matcher.sv
// Top level: dictionary, per-phase sliding windows and the sequencer that walks them.
// Add word: a dictionary scan, one dictionary entry compared per cycle. Text byte: if a
// word completes, the dictionary scan, the window pops, the push, a check and a result
// load follow; after a word_length write the remainder unit first recomputes the phase.
// One item at a time; req_tready is high only while the sequencer is idle.
// Synchronous active-high reset: empty dictionary and windows, word_length 1.
`timescale 1ns / 1ps
`default_nettype none
module word_concatenation_matcher
   import wcm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // word_chars[63:0], text_char[71:64]
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // start_index[31:0]
   output logic [1:0]       rsp_tuser,   // kind[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data
);

   state_type state_ff, state_in;
   ctx_type   ctx_ff,   ctx_in;

   logic [3:0]       wlen_ff, wlen_in;
   logic [63:0]      dword_ff [MAX_WORDS];
   logic [63:0]      dword_in [MAX_WORDS];
   logic [NUM_W-1:0] need_ff  [MAX_WORDS];
   logic [NUM_W-1:0] need_in  [MAX_WORDS];
   logic [NUM_W-1:0] entries_ff, entries_in;
   logic [NUM_W-1:0] total_ff,   total_in;
   logic [63:0]      hist_ff,    hist_in;
   logic [31:0]      pos_ff,     pos_in;
   logic [ENT_W-1:0] head_ff [MAX_WORD_LEN];
   logic [ENT_W-1:0] head_in [MAX_WORD_LEN];
   logic [NUM_W-1:0] len_ff  [MAX_WORD_LEN];
   logic [NUM_W-1:0] len_in  [MAX_WORD_LEN];
   logic [31:0]      left_ff [MAX_WORD_LEN];
   logic [31:0]      left_in [MAX_WORD_LEN];
   logic [SLOTS-1:0] vld_ff, vld_in;
   logic [PH_W-1:0]  nxt_ph_ff, nxt_ph_in;
   logic [PH_W-1:0]  cur_ph_ff, cur_ph_in;
   logic             stale_ff,  stale_in;
   logic [31:0]      j_ff,      j_in;
   logic [63:0]      w_ff,      w_in;
   logic [ENT_W-1:0] idx_ff,    idx_in;
   logic [ENT_W-1:0] e_ff,      e_in;
   logic [ENT_W-1:0] pop_e_ff,  pop_e_in;
   logic [NUM_W-1:0] cnt_e_ff,  cnt_e_in;
   logic             op_add_ff, op_add_in;
   logic [1:0]       res_kind_ff, res_kind_in;
   logic [31:0]      res_idx_ff,  res_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff,  rsp_kind_in;
   logic [31:0]      rsp_idx_ff,   rsp_idx_in;

   logic [3:0]       l;
   logic             accept;
   action_type       act;
   logic [63:0]      new_hist;
   logic [31:0]      pos_inc;
   logic             hit, last;
   logic             emit_ok;
   logic [NUM_W-1:0] cnt_old;
   logic             mod_start, mod_done;
   logic [PH_W-1:0]  mod_rem;

   logic             cnt_we, ring_we;
   logic [SLOT_W-1:0] cnt_waddr, cnt_raddr, ring_waddr, ring_raddr;
   logic [NUM_W-1:0] cnt_wdata, cnt_rdata;
   logic [ENT_W-1:0] ring_wdata, ring_rdata;

   function automatic logic [PH_W-1:0] ph_wrap(input logic [PH_W-1:0] ph,
                                               input logic [3:0] len);
      logic [3:0] n;
      n = 4'(ph) + 4'd1;
      return (n == len) ? '0 : PH_W'(n);
   endfunction

   assign l          = eff_len(wlen_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign act        = action_type'(req_tuser);
   assign new_hist   = {req_tdata[71:64], hist_ff[63:8]};
   assign pos_inc    = pos_ff + 32'd1;
   assign hit        = (entries_ff != '0) && (dword_ff[idx_ff] == w_ff);
   assign last       = (entries_ff == '0) || ((NUM_W'(idx_ff) + NUM_W'(1)) == entries_ff);
   assign emit_ok    = !rsp_valid_ff || rsp_tready;
   assign cnt_old    = vld_ff[{cur_ph_ff, (state_ff == S_POP_WR) ? pop_e_ff : e_ff}]
                       ? cnt_rdata : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_idx_ff;

   wcm_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (j_in),
      .divisor  (l),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   wcm_ram #(.WIDTH(NUM_W), .DEPTH(SLOTS)) u_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   wcm_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (act)
                  ACT_ADD: state_in = (total_ff >= NUM_W'(MAX_WORDS)) ? S_EMIT : S_SEARCH;
                  ACT_TEXT: begin
                     if (pos_ff == '1) state_in = S_EMIT;
                     else if (pos_inc >= 32'(l)) state_in = stale_ff ? S_MOD : S_SEARCH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MOD:      if (mod_done) state_in = S_SEARCH;
         S_SEARCH: begin
            if (hit) begin
               if (op_add_ff) state_in = S_IDLE;
               else state_in = len_ff[cur_ph_ff][ENT_W] ? S_POP_RING : S_PUSH_RD;
            end else if (last) begin
               state_in = S_IDLE;
            end
         end
         S_POP_RING: state_in = S_POP_CNT;
         S_POP_CNT:  state_in = S_POP_WR;
         S_POP_WR: begin
            unique case (ctx_ff)
               CTX_PRE:  state_in = S_PUSH_RD;
               CTX_LOOP: state_in = S_CHECK;
               default:  state_in = S_IDLE;
            endcase
         end
         S_PUSH_RD:  state_in = S_PUSH_WR;
         S_PUSH_WR:  state_in = S_CHECK;
         S_CHECK: begin
            if (cnt_e_ff > need_ff[e_ff] && len_ff[cur_ph_ff] != '0) state_in = S_POP_RING;
            else if (total_ff != '0 && len_ff[cur_ph_ff] == total_ff) state_in = S_EMIT;
            else state_in = S_IDLE;
         end
         S_EMIT: begin
            if (emit_ok) state_in = (ctx_ff == CTX_FINAL) ? S_POP_RING : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      wlen_in     = wlen_ff;
      dword_in    = dword_ff;
      need_in     = need_ff;
      entries_in  = entries_ff;
      total_in    = total_ff;
      hist_in     = hist_ff;
      pos_in      = pos_ff;
      head_in     = head_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      vld_in      = vld_ff;
      nxt_ph_in   = nxt_ph_ff;
      cur_ph_in   = cur_ph_ff;
      stale_in    = stale_ff;
      j_in        = j_ff;
      w_in        = w_ff;
      idx_in      = idx_ff;
      e_in        = e_ff;
      pop_e_in    = pop_e_ff;
      cnt_e_in    = cnt_e_ff;
      op_add_in   = op_add_ff;
      ctx_in      = ctx_ff;
      res_kind_in = res_kind_ff;
      res_idx_in  = res_idx_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mod_start   = 1'b0;
      cnt_we      = 1'b0;
      cnt_waddr   = {cur_ph_ff, pop_e_ff};
      cnt_wdata   = '0;
      cnt_raddr   = {cur_ph_ff, e_ff};
      ring_we     = 1'b0;
      ring_waddr  = {cur_ph_ff, ENT_W'(head_ff[cur_ph_ff] + len_ff[cur_ph_ff][ENT_W-1:0])};
      ring_wdata  = e_ff;
      ring_raddr  = {cur_ph_ff, head_ff[cur_ph_ff]};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
               ctx_in = CTX_PRE;
               unique case (act)
                  ACT_CLEAR, ACT_RESTART: begin
                     if (act == ACT_CLEAR) begin
                        for (int k = 0; k < MAX_WORDS; k++) need_in[k] = '0;
                        entries_in = '0;
                        total_in   = '0;
                     end
                     hist_in   = '0;
                     pos_in    = '0;
                     vld_in    = '0;
                     nxt_ph_in = '0;
                     stale_in  = 1'b0;
                     for (int p = 0; p < MAX_WORD_LEN; p++) begin
                        head_in[p] = '0;
                        len_in[p]  = '0;
                        left_in[p] = 32'(p);
                     end
                  end
                  ACT_ADD: begin
                     op_add_in   = 1'b1;
                     w_in        = req_tdata[63:0] & len_mask(l);
                     res_kind_in = KIND_DICT_FULL;
                     res_idx_in  = '0;
                  end
                  ACT_TEXT: begin
                     op_add_in   = 1'b0;
                     res_kind_in = KIND_POS_SAT;
                     res_idx_in  = '0;
                     if (pos_ff != '1) begin
                        hist_in = new_hist;
                        pos_in  = pos_inc;
                        j_in    = pos_inc - 32'(l);
                        w_in    = new_hist >> {3'(4'd8 - l), 3'b000};
                        if (pos_inc >= 32'(l)) begin
                           if (stale_ff) begin
                              mod_start = 1'b1;
                           end else begin
                              cur_ph_in = nxt_ph_ff;
                              nxt_ph_in = ph_wrap(nxt_ph_ff, l);
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MOD: begin
            if (mod_done) begin
               cur_ph_in = mod_rem;
               nxt_ph_in = ph_wrap(mod_rem, l);
               stale_in  = 1'b0;
            end
         end
         S_SEARCH: begin
            if (hit) begin
               if (op_add_ff) begin
                  need_in[idx_ff] = need_ff[idx_ff] + NUM_W'(1);
                  total_in        = total_ff + NUM_W'(1);
               end else begin
                  e_in = idx_ff;
               end
            end else if (last) begin
               if (op_add_ff) begin
                  dword_in[entries_ff[ENT_W-1:0]] = w_ff;
                  need_in[entries_ff[ENT_W-1:0]]  = NUM_W'(1);
                  entries_in = entries_ff + NUM_W'(1);
                  total_in   = total_ff + NUM_W'(1);
               end else begin
                  for (int k = 0; k < MAX_WORDS; k++) vld_in[{cur_ph_ff, ENT_W'(k)}] = 1'b0;
                  head_in[cur_ph_ff] = '0;
                  len_in[cur_ph_ff]  = '0;
                  left_in[cur_ph_ff] = j_ff + 32'(l);
               end
            end else begin
               idx_in = idx_ff + ENT_W'(1);
            end
         end
         S_POP_RING: ;
         S_POP_CNT: begin
            pop_e_in  = ring_rdata;
            cnt_raddr = {cur_ph_ff, ring_rdata};
         end
         S_POP_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = {cur_ph_ff, pop_e_ff};
            cnt_wdata = (cnt_old != '0) ? cnt_old - NUM_W'(1) : '0;
            vld_in[{cur_ph_ff, pop_e_ff}] = 1'b1;
            if (pop_e_ff == e_ff) cnt_e_in = cnt_wdata;
            head_in[cur_ph_ff] = head_ff[cur_ph_ff] + ENT_W'(1);
            len_in[cur_ph_ff]  = len_ff[cur_ph_ff] - NUM_W'(1);
            left_in[cur_ph_ff] = left_ff[cur_ph_ff] + 32'(l);
         end
         S_PUSH_RD: begin
            ring_we   = 1'b1;
            cnt_raddr = {cur_ph_ff, e_ff};
         end
         S_PUSH_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = {cur_ph_ff, e_ff};
            cnt_wdata = cnt_old + NUM_W'(1);
            vld_in[{cur_ph_ff, e_ff}] = 1'b1;
            cnt_e_in  = cnt_wdata;
            len_in[cur_ph_ff] = len_ff[cur_ph_ff] + NUM_W'(1);
         end
         S_CHECK: begin
            if (cnt_e_ff > need_ff[e_ff] && len_ff[cur_ph_ff] != '0) begin
               ctx_in = CTX_LOOP;
            end else begin
               ctx_in      = CTX_FINAL;
               res_kind_in = KIND_MATCH;
               res_idx_in  = left_ff[cur_ph_ff];
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_idx_in   = res_idx_ff;
            end
         end
         default: ;
      endcase

      if (csr_valid) begin
         wlen_in  = csr_data;
         stale_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dword_ff    <= dword_in;
      hist_ff     <= hist_in;
      j_ff        <= j_in;
      w_ff        <= w_in;
      idx_ff      <= idx_in;
      e_ff        <= e_in;
      pop_e_ff    <= pop_e_in;
      cnt_e_ff    <= cnt_e_in;
      op_add_ff   <= op_add_in;
      res_kind_ff <= res_kind_in;
      res_idx_ff  <= res_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ctx_ff       <= CTX_PRE;
         wlen_ff      <= 4'd1;
         for (int k = 0; k < MAX_WORDS; k++) need_ff[k] <= '0;
         entries_ff   <= '0;
         total_ff     <= '0;
         pos_ff       <= '0;
         for (int p = 0; p < MAX_WORD_LEN; p++) begin
            head_ff[p] <= '0;
            len_ff[p]  <= '0;
            left_ff[p] <= 32'(p);
         end
         vld_ff       <= '0;
         nxt_ph_ff    <= '0;
         cur_ph_ff    <= '0;
         stale_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         wlen_ff      <= wlen_in;
         need_ff      <= need_in;
         entries_ff   <= entries_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         head_ff      <= head_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         vld_ff       <= vld_in;
         nxt_ph_ff    <= nxt_ph_in;
         cur_ph_ff    <= cur_ph_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_entries_le_total: assert property (@(posedge clock) disable iff (reset)
      entries_ff <= total_ff)
      else $error("distinct entries exceed total words");

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff[cur_ph_ff] <= NUM_W'(MAX_WORDS))
      else $error("phase window longer than dictionary capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_WR |-> len_ff[cur_ph_ff] != '0)
      else $error("pop from empty window");

   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_MOD)
      else $error("remainder unit finished outside its wait state");

endmodule
`default_nettype wire

// File: rtl/wcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/wcm_mod_unit.sv
// Bit-serial remainder of a 32-bit index by the word length.
`timescale 1ns / 1ps
`default_nettype none
module wcm_mod_unit
   import wcm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [31:0]     dividend,
   input  wire logic [3:0]      divisor,
   output logic                 done,
   output logic [PH_W-1:0]      rem
);

   logic [31:0]     sh_ff,   sh_in;
   logic [PH_W-1:0] rem_ff,  rem_in;
   logic [4:0]      cnt_ff,  cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [PH_W:0]   trial;

   always_comb begin
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, sh_ff[31]};
      if (start) begin
         sh_in   = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[30:0], 1'b0};
         if ((PH_W+1)'(divisor) <= trial) rem_in = PH_W'(trial - (PH_W+1)'(divisor));
         else rem_in = PH_W'(trial);
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire
